@@ hdl/assert_macros.svh @@
// assertion macros shared by the gpio edge-detect register block
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gpio_ed_pkg.sv @@
// types, codes and constants of the gpio edge-detect register block
// no dependencies; used by gpio_ed_regs and the top level
package gpio_ed_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 2;
    localparam int IDX_W           = 4;
    localparam int PIN_COUNT_DEF   = 32;
    localparam int PINS_PER_SELECT = 10;
    localparam int FSEL_W          = 3;
    localparam int FSEL_REGS       = 4;
    localparam int FSEL_SEL_W      = $clog2(FSEL_REGS);

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    localparam logic [IDX_W-1:0] REG_FSEL0 = 4'd0;
    localparam logic [IDX_W-1:0] REG_FSEL1 = 4'd1;
    localparam logic [IDX_W-1:0] REG_FSEL2 = 4'd2;
    localparam logic [IDX_W-1:0] REG_FSEL3 = 4'd3;
    localparam logic [IDX_W-1:0] REG_SET   = 4'd4;
    localparam logic [IDX_W-1:0] REG_CLR   = 4'd5;
    localparam logic [IDX_W-1:0] REG_LEV   = 4'd6;
    localparam logic [IDX_W-1:0] REG_EVT   = 4'd7;
    localparam logic [IDX_W-1:0] REG_RISE  = 4'd8;
    localparam logic [IDX_W-1:0] REG_FALL  = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] levels;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [DATA_W-1:0] latch;
        logic              pending;
    } res_t;

endpackage

@@ hdl/gpio_register_block_edge_detect.sv @@
// GPIO register block with edge detection, one bank of pins. Each request is a
// register read, a register write or a pin sample, and gives exactly one
// response carrying the read data, the output latch and an event-pending flag.
// One request is taken every cycle while the response side is not stalled; a
// request passes through the request register and then the response register,
// with the register update between them. Register state changes as a request
// leaves the request register, so back-to-back requests see each other's writes.
// Depends on gpio_ed_pkg, gpio_ed_regs and assert_macros.svh.
`include "assert_macros.svh"

module gpio_register_block_edge_detect #(
    parameter int PIN_COUNT = gpio_ed_pkg::PIN_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gpio_ed_pkg::OP_W-1:0]         operation,
    input  logic [gpio_ed_pkg::IDX_W-1:0]        reg_index,
    input  logic [gpio_ed_pkg::DATA_W-1:0]       write_data,
    input  logic [gpio_ed_pkg::DATA_W-1:0]       pin_levels,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gpio_ed_pkg::DATA_W-1:0]       read_data,
    output logic [gpio_ed_pkg::DATA_W-1:0]       output_latch,
    output logic                                 event_pending
);
    import gpio_ed_pkg::*;

    localparam logic [63:0]       MASK64   = (64'd1 << PIN_COUNT) - 64'd1;
    localparam logic [DATA_W-1:0] PIN_MASK = MASK64[DATA_W-1:0];

    logic s1_valid_reg, s1_valid_next;
    req_t s1_reg;
    logic s1_go;
    logic out_valid_reg, out_valid_next;
    res_t out_reg;
    res_t res;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg.op     <= operation;
            s1_reg.idx    <= reg_index;
            s1_reg.data   <= write_data;
            s1_reg.levels <= pin_levels;
        end
        if (s1_go)
        begin
            out_reg <= res;
        end
    end

    gpio_ed_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (s1_go),
        .req    (s1_reg),
        .res    (res)
    );

    assign out_valid     = out_valid_reg;
    assign read_data     = out_reg.rdata;
    assign output_latch  = out_reg.latch;
    assign event_pending = out_reg.pending;

    `ASSERT_ALWAYS(a_ready_when_empty, clk, rst_n,
        out_valid_reg || in_ready, "request side stalled with empty response register")
    `ASSERT_ALWAYS(a_latch_in_range, clk, rst_n,
        !out_valid_reg || ((output_latch & ~PIN_MASK) == '0), "latch bit beyond pin count")
    `ASSERT_NEXT(a_set_takes, clk, rst_n,
        s1_go && s1_reg.op == OP_WRITE && s1_reg.idx == REG_SET,
        (output_latch & $past(s1_reg.data) & PIN_MASK) == ($past(s1_reg.data) & PIN_MASK),
        "set write did not reach the output latch")

endmodule

@@ hdl/gpio_ed_regs.sv @@
// register file of the gpio edge-detect block: function select, output latch,
// edge enables, event status and last sampled levels; uses gpio_ed_pkg
module gpio_ed_regs #(
    parameter int PIN_COUNT = gpio_ed_pkg::PIN_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  gpio_ed_pkg::req_t  req,
    output gpio_ed_pkg::res_t  res
);
    import gpio_ed_pkg::*;

    localparam logic [63:0]       MASK64   = (64'd1 << PIN_COUNT) - 64'd1;
    localparam logic [DATA_W-1:0] PIN_MASK = MASK64[DATA_W-1:0];

    logic [FSEL_W-1:0] func_reg  [PIN_COUNT];
    logic [FSEL_W-1:0] func_next [PIN_COUNT];
    logic [DATA_W-1:0] latch_reg, latch_next;
    logic [DATA_W-1:0] rise_reg, rise_next;
    logic [DATA_W-1:0] fall_reg, fall_next;
    logic [DATA_W-1:0] evt_reg, evt_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic [DATA_W-1:0] fsel_word [FSEL_REGS];
    logic [DATA_W-1:0] now_lev;
    logic [DATA_W-1:0] rises;
    logic [DATA_W-1:0] falls;
    logic [DATA_W-1:0] rdata;
    logic              wr;

    // packed view of the function-select fields
    always_comb
    begin
        int p;
        for (int r = 0; r < FSEL_REGS; r++)
        begin
            fsel_word[r] = '0;
            for (int k = 0; k < PINS_PER_SELECT; k++)
            begin
                p = r * PINS_PER_SELECT + k;
                if (p < PIN_COUNT)
                begin
                    fsel_word[r][k*FSEL_W +: FSEL_W] = func_reg[p];
                end
            end
        end
    end

    assign wr      = (req.op == OP_WRITE);
    assign now_lev = req.levels & PIN_MASK;
    assign rises   = now_lev & ~last_reg;
    assign falls   = ~now_lev & last_reg;

    always_comb
    begin
        for (int p = 0; p < PIN_COUNT; p++)
        begin
            func_next[p] = func_reg[p];
            if (wr && req.idx == REG_FSEL0 + IDX_W'(p / PINS_PER_SELECT))
            begin
                func_next[p] = req.data[(p % PINS_PER_SELECT)*FSEL_W +: FSEL_W];
            end
        end
    end

    always_comb
    begin
        latch_next = latch_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        evt_next   = evt_reg;
        last_next  = last_reg;
        if (wr)
        begin
            unique case (req.idx)
                REG_SET:  latch_next = (latch_reg | req.data) & PIN_MASK;
                REG_CLR:  latch_next = latch_reg & ~req.data & PIN_MASK;
                REG_EVT:  evt_next   = evt_reg & ~req.data & PIN_MASK;
                REG_RISE: rise_next  = req.data & PIN_MASK;
                REG_FALL: fall_next  = req.data & PIN_MASK;
                default:  ;
            endcase
        end
        else if (req.op == OP_SAMPLE)
        begin
            evt_next  = (evt_reg | (rises & rise_reg) | (falls & fall_reg)) & PIN_MASK;
            last_next = now_lev;
        end
    end

    always_comb
    begin
        rdata = '0;
        if (req.op == OP_READ)
        begin
            unique case (req.idx) inside
                REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3:
                    rdata = fsel_word[req.idx[FSEL_SEL_W-1:0]];
                REG_LEV:  rdata = last_reg;
                REG_EVT:  rdata = evt_reg;
                REG_RISE: rdata = rise_reg;
                REG_FALL: rdata = fall_reg;
                default:  rdata = '0;
            endcase
        end
    end

    assign res.rdata   = rdata;
    assign res.latch   = latch_next;
    assign res.pending = |evt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PIN_COUNT; p++)
            begin
                func_reg[p] <= '0;
            end
            latch_reg <= '0;
            rise_reg  <= '0;
            fall_reg  <= '0;
            evt_reg   <= '0;
            last_reg  <= '0;
        end
        else if (commit)
        begin
            for (int p = 0; p < PIN_COUNT; p++)
            begin
                func_reg[p] <= func_next[p];
            end
            latch_reg <= latch_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            evt_reg   <= evt_next;
            last_reg  <= last_next;
        end
    end

endmodule
